FILE: src/assert_macros.svh
// assertion macros for the floppy motor timer
// used by the top level only; needs a clock and an active-low reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define FMT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define FMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/fmt_pkg.sv
// shared types and constants of the floppy motor timer
// used by fmt_lane, fmt_step and floppy_motor_timer; no dependencies
package fmt_pkg;

	// drive count and timer widths
	localparam int unsigned NUM_DRIVES = 4;
	localparam int unsigned MAX_DRIVES = 4;
	localparam int unsigned TIMER_W    = 16;

	// register image bits
	localparam logic [7:0] MOTOR_BASE   = 8'h10;
	localparam logic [7:0] SELECT_CLEAR = 8'hFC;
	localparam logic [7:0] MOTOR_BITS   = 8'hF0;
	localparam logic [7:0] DOR_RESET    = 8'h0C;
	localparam int unsigned MOTOR_LSB   = 4;

	// timer reset values and minimum select-only spin
	localparam logic [TIMER_W-1:0] SPINUP_RESET    = 16'd50;
	localparam logic [TIMER_W-1:0] OFF_DELAY_RESET = 16'd300;
	localparam logic [TIMER_W-1:0] ON_HOLD_RESET   = 16'd10000;
	localparam logic [TIMER_W-1:0] MIN_SELECT_SPIN = 16'd2;

	// operation codes
	localparam logic [1:0] OP_ON   = 2'd0;
	localparam logic [1:0] OP_OFF  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SPINUP    = 2'd0;
	localparam logic [1:0] REG_OFF_DELAY = 2'd1;
	localparam logic [1:0] REG_ON_HOLD   = 2'd2;

	// one request or tick, operation in the lowest bits
	typedef struct packed {
		logic       drive_selected;
		logic [1:0] drive;
		logic [1:0] operation;
	} item_t;

	// one result, register image in the lowest bits
	typedef struct packed {
		logic [MAX_DRIVES-1:0] wake_mask;
		logic [TIMER_W-1:0]    ticks_to_ready;
		logic                  dor_written;
		logic [7:0]            dor_value;
	} result_t;

	// register image and per-drive timers
	typedef struct packed {
		logic [7:0]                         dor;
		logic [MAX_DRIVES-1:0][TIMER_W-1:0] spin;
		logic [MAX_DRIVES-1:0][TIMER_W-1:0] off;
	} state_t;

	// configuration registers
	typedef struct packed {
		logic [TIMER_W-1:0] spinup;
		logic [TIMER_W-1:0] off_delay;
		logic [TIMER_W-1:0] on_hold;
	} cfg_t;

endpackage

FILE: src/floppy_motor_timer.sv
// Floppy motor on/off timer for four drives, top level.
// The input register loads on the transfer and the result register loads from it when it
// advances. Throughput: one item per cycle while the result stream does not stall.
// A stalled result register holds the input register; the input still takes an item
// while a finished result waits, as long as the input register is empty. Reset (arst_n
// low) clears valids, image to 0x0C, timers to zero, config registers to 50, 300, 10000.
module floppy_motor_timer (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // operation[1:0], drive[3:2], drive_selected[4], zero fill
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // dor_value[7:0], dor_written[8], ticks_to_ready[24:9],
	                               // wake_mask[28:25], zero fill
);

`include "assert_macros.svh"

	fmt_pkg::item_t   item_s1;
	logic             vld_s1;
	fmt_pkg::result_t res_s2;
	logic             vld_s2;
	fmt_pkg::state_t  state_q;
	fmt_pkg::cfg_t    cfg_q;
	fmt_pkg::state_t  state_nx;
	fmt_pkg::result_t res_nx;
	logic             adv;
	logic [fmt_pkg::MAX_DRIVES-1:0] spin_nz;

	// item moves to the result register when that register is free or drains
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = vld_s2;
	assign m_tdata  = {3'b000, res_s2};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spinup    <= fmt_pkg::SPINUP_RESET;
			cfg_q.off_delay <= fmt_pkg::OFF_DELAY_RESET;
			cfg_q.on_hold   <= fmt_pkg::ON_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmt_pkg::REG_SPINUP:    cfg_q.spinup    <= cfg_wdata;
				fmt_pkg::REG_OFF_DELAY: cfg_q.off_delay <= cfg_wdata;
				fmt_pkg::REG_ON_HOLD:   cfg_q.on_hold   <= cfg_wdata;
				default: begin
					// no register at this index
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= fmt_pkg::item_t'(s_tdata[4:0]);
	end

	// state update and result computation
	fmt_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nx),
		.res  (res_nx)
	);

	// drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dor  <= fmt_pkg::DOR_RESET;
			state_q.spin <= '0;
			state_q.off  <= '0;
		end else if (adv) begin
			state_q <= state_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nx;
	end

	// drives whose spin-up timer still runs
	always_comb begin
		for (int i = 0; i < fmt_pkg::MAX_DRIVES; i++)
			spin_nz[i] = (state_q.spin[i] != '0);
	end

	// checks
	`FMT_ASSERT_NEXT(a_on_sets_motor, adv && item_s1.operation == fmt_pkg::OP_ON,
		(state_q.dor & fmt_pkg::MOTOR_BITS) != 8'h00, "on request left all motors off")
	`FMT_ASSERT_NEXT(a_wake_spin_zero, adv,
		(res_s2.wake_mask & spin_nz) == '0, "wake flagged while spin-up still running")
	`FMT_ASSERT_IMPL(a_full_stall, vld_s1 && vld_s2 && !m_tready, !s_tready,
		"input taken while both stages are stalled")

endmodule

FILE: src/fmt_lane.sv
// tick update of one drive: spin-up countdown, off countdown, motor clear
// depends on fmt_pkg
module fmt_lane (
	input  logic                         motor_on,
	input  logic [fmt_pkg::TIMER_W-1:0]  spin,
	input  logic [fmt_pkg::TIMER_W-1:0]  off,
	output logic [fmt_pkg::TIMER_W-1:0]  spin_nx,
	output logic [fmt_pkg::TIMER_W-1:0]  off_nx,
	output logic                         wake,
	output logic                         clear_motor
);

	// spin-up has priority, then turn-off, then off countdown
	always_comb begin
		spin_nx     = spin;
		off_nx      = off;
		wake        = 1'b0;
		clear_motor = 1'b0;
		if (motor_on) begin
			if (spin != '0) begin
				spin_nx = spin - 1'b1;
				wake    = (spin == fmt_pkg::TIMER_W'(1));
			end else if (off == '0) begin
				clear_motor = 1'b1;
			end else begin
				off_nx = off - 1'b1;
			end
		end
	end

endmodule

FILE: src/fmt_step.sv
// next state and result for one item, from the current state and config
// depends on fmt_pkg and fmt_lane
module fmt_step (
	input  fmt_pkg::item_t   item,
	input  fmt_pkg::state_t  cur,
	input  fmt_pkg::cfg_t    cfg,
	output fmt_pkg::state_t  nxt,
	output fmt_pkg::result_t res
);

	logic [fmt_pkg::MAX_DRIVES-1:0][fmt_pkg::TIMER_W-1:0] tick_spin;
	logic [fmt_pkg::MAX_DRIVES-1:0][fmt_pkg::TIMER_W-1:0] tick_off;
	logic [fmt_pkg::MAX_DRIVES-1:0]                       tick_wake;
	logic [fmt_pkg::MAX_DRIVES-1:0]                       tick_clear;
	logic                                                 drive_ok;
	logic [7:0]                                           img;

	// one timer lane per drive that exists
	for (genvar i = 0; i < fmt_pkg::MAX_DRIVES; i++) begin : g_lane
		if (i < fmt_pkg::NUM_DRIVES) begin : g_on
			fmt_lane u_lane (
				.motor_on    (cur.dor[fmt_pkg::MOTOR_LSB + i]),
				.spin        (cur.spin[i]),
				.off         (cur.off[i]),
				.spin_nx     (tick_spin[i]),
				.off_nx      (tick_off[i]),
				.wake        (tick_wake[i]),
				.clear_motor (tick_clear[i])
			);
		end else begin : g_off
			assign tick_spin[i]  = cur.spin[i];
			assign tick_off[i]   = cur.off[i];
			assign tick_wake[i]  = 1'b0;
			assign tick_clear[i] = 1'b0;
		end
	end

	assign drive_ok = 32'(item.drive) < fmt_pkg::NUM_DRIVES;

	// image an on request would produce
	always_comb begin
		img = cur.dor | 8'(fmt_pkg::MOTOR_BASE << item.drive);
		if (!item.drive_selected)
			img = (img & fmt_pkg::SELECT_CLEAR) | {6'b0, item.drive};
	end

	// state update and result by operation
	always_comb begin
		nxt = cur;
		res = '0;
		unique case (item.operation)
			fmt_pkg::OP_ON: begin
				if (drive_ok) begin
					nxt.off[item.drive] = cfg.on_hold;
					if (img != cur.dor) begin
						res.dor_written = 1'b1;
						nxt.dor         = img;
						if (((img ^ cur.dor) & fmt_pkg::MOTOR_BITS) != 8'h00)
							nxt.spin[item.drive] = cfg.spinup;
						else if (cur.spin[item.drive] < fmt_pkg::MIN_SELECT_SPIN)
							nxt.spin[item.drive] = fmt_pkg::MIN_SELECT_SPIN;
					end
				end
			end
			fmt_pkg::OP_OFF: begin
				if (drive_ok)
					nxt.off[item.drive] = cfg.off_delay;
			end
			fmt_pkg::OP_TICK: begin
				nxt.spin        = tick_spin;
				nxt.off         = tick_off;
				nxt.dor         = cur.dor & ~{tick_clear, 4'b0000};
				res.dor_written = |tick_clear;
				res.wake_mask   = tick_wake;
			end
			default: begin
				// unused code leaves everything as it is
			end
		endcase
		res.dor_value      = nxt.dor;
		res.ticks_to_ready = drive_ok ? nxt.spin[item.drive] : '0;
	end

endmodule
